// ===== sv/sida_pkg.sv =====
// Shared constants, types and helpers for the signed integer to decimal text converter.
`timescale 1ns / 1ps
`default_nettype none
package sida_pkg;

    localparam int ValueWidth    = 32;
    localparam int NumDigits     = 10;
    localparam int BitsPerStep   = 4;
    localparam int NumSteps      = ValueWidth / BitsPerStep;
    localparam int StepCntWidth  = $clog2(NumSteps);
    localparam int DigitIdxWidth = $clog2(NumDigits);
    localparam int CharWidth     = 6;

    localparam logic [CharWidth-1:0] CharZero  = CharWidth'(48);
    localparam logic [CharWidth-1:0] CharMinus = CharWidth'(45);

    typedef logic [3:0] t_digit;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_COUNT,
        ST_EMIT
    } t_state;

    // control broadcast to every digit cell
    typedef struct packed {
        logic load;
        logic step;
    } t_cell_ctrl;

    // shift-and-add-3 correction before each shift
    function automatic t_digit dabble_adj(input t_digit d);
        return (d >= 4'd5) ? t_digit'(d + 4'd3) : d;
    endfunction

endpackage
`default_nettype wire

// ===== sv/sida_if.sv =====
// Valid/ready channel interfaces for the input value and the output characters.
`timescale 1ns / 1ps
`default_nettype none
interface sida_in_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [sida_pkg::ValueWidth-1:0]   value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sida_out_if;
    logic                               valid;
    logic                               ready;
    logic [sida_pkg::CharWidth-1:0]     char_code;
    logic                               is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface
`default_nettype wire

// ===== sv/sida_cell.sv =====
// One BCD digit cell of the double-dabble chain; handles several shift steps per cycle.
`timescale 1ns / 1ps
`default_nettype none
module sida_cell (
    input  logic                                i_clk,
    input  sida_pkg::t_cell_ctrl                i_ctrl,
    input  logic [sida_pkg::BitsPerStep-1:0]    i_bits,
    output logic [sida_pkg::BitsPerStep-1:0]    o_bits,
    output sida_pkg::t_digit                    o_digit
);

    sida_pkg::t_digit r_digit;
    sida_pkg::t_digit n_digit;

    // i_bits[msb] is the first bit in time; o_bits follows the same order
    always_comb begin
        sida_pkg::t_digit d;
        d = r_digit;
        o_bits = '0;
        for (int j = 0; j < sida_pkg::BitsPerStep; j++) begin
            d = sida_pkg::dabble_adj(d);
            o_bits[sida_pkg::BitsPerStep-1-j] = d[3];
            d = {d[2:0], i_bits[sida_pkg::BitsPerStep-1-j]};
        end
        if (i_ctrl.load) begin
            n_digit = '0;
        end else if (i_ctrl.step) begin
            n_digit = d;
        end else begin
            n_digit = r_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_digit = r_digit;

endmodule
`default_nettype wire

// ===== sv/signed_int_to_decimal_ascii.sv =====
// Top level: signed 32-bit integer to decimal ASCII characters, one per output item.
`timescale 1ns / 1ps
`default_nettype none
// Takes one signed 32-bit value per input item and sends its decimal text, one ASCII
// character per output item: '-' first for a negative value, then the digits most
// significant first with no leading zeros, is_last set on the final digit. The binary
// magnitude is shifted four bits a cycle into a row of ten BCD digit cells (double
// dabble); the leading digit is then found in the count state, and the characters
// (1 to 11) are sent one per cycle while the output accepts them. No new item is
// taken while one is in progress; the next item is taken once the last character
// has entered the output register.
module signed_int_to_decimal_ascii (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sida_in_if.sink           i_in,
    sida_out_if.source        o_out
);

    sida_pkg::t_state                          r_state;
    sida_pkg::t_state                          n_state;
    logic [sida_pkg::StepCntWidth-1:0]         r_step;
    logic [sida_pkg::ValueWidth-1:0]           r_mag;
    logic                                      r_neg_pend;
    logic [sida_pkg::DigitIdxWidth-1:0]        r_idx;
    logic                                      r_out_valid;
    logic [sida_pkg::CharWidth-1:0]            r_char;
    logic                                      r_last;

    sida_pkg::t_cell_ctrl                      w_ctrl;
    logic                                      w_emit;
    logic                                      w_in_ready;
    logic [sida_pkg::ValueWidth-1:0]           w_raw;
    logic [sida_pkg::ValueWidth-1:0]           w_mag;
    logic [sida_pkg::DigitIdxWidth-1:0]        w_top;
    logic [sida_pkg::BitsPerStep-1:0]          w_carry [0:sida_pkg::NumDigits];
    sida_pkg::t_digit                          w_digit [0:sida_pkg::NumDigits-1];

    assign w_raw = i_in.value;
    assign w_mag = w_raw[sida_pkg::ValueWidth-1] ? (sida_pkg::ValueWidth'(0) - w_raw) : w_raw;

    // digit chain
    assign w_carry[0] = r_mag[sida_pkg::ValueWidth-1 -: sida_pkg::BitsPerStep];

    for (genvar g = 0; g < sida_pkg::NumDigits; g++) begin : g_cell
        sida_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_bits  (w_carry[g]),
            .o_bits  (w_carry[g+1]),
            .o_digit (w_digit[g])
        );
    end

    // highest nonzero digit; zero value leaves index 0 so a single '0' goes out
    always_comb begin
        w_top = '0;
        for (int i = 0; i < sida_pkg::NumDigits; i++) begin
            if (w_digit[i] != '0) begin
                w_top = sida_pkg::DigitIdxWidth'(i);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sida_pkg::ST_IDLE: begin
                if (i_in.valid) n_state = sida_pkg::ST_CONV;
            end
            sida_pkg::ST_CONV: begin
                if (r_step == sida_pkg::StepCntWidth'(sida_pkg::NumSteps - 1)) begin
                    n_state = sida_pkg::ST_COUNT;
                end
            end
            sida_pkg::ST_COUNT: begin
                n_state = sida_pkg::ST_EMIT;
            end
            sida_pkg::ST_EMIT: begin
                if (w_emit && !r_neg_pend && r_idx == '0) n_state = sida_pkg::ST_IDLE;
            end
            default: n_state = sida_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_in_ready  = 1'b0;
        w_ctrl.load = 1'b0;
        w_ctrl.step = 1'b0;
        w_emit      = 1'b0;
        unique case (r_state)
            sida_pkg::ST_IDLE: begin
                w_in_ready  = 1'b1;
                w_ctrl.load = i_in.valid;
            end
            sida_pkg::ST_CONV: begin
                w_ctrl.step = 1'b1;
            end
            sida_pkg::ST_COUNT: begin
            end
            sida_pkg::ST_EMIT: begin
                w_emit = !r_out_valid || o_out.ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sida_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.load) begin
            r_mag      <= w_mag;
            r_neg_pend <= w_raw[sida_pkg::ValueWidth-1];
            r_step     <= '0;
        end else if (w_ctrl.step) begin
            r_mag  <= {r_mag[sida_pkg::ValueWidth-sida_pkg::BitsPerStep-1:0],
                       {sida_pkg::BitsPerStep{1'b0}}};
            r_step <= r_step + sida_pkg::StepCntWidth'(1);
        end
        if (r_state == sida_pkg::ST_COUNT) begin
            r_idx <= w_top;
        end
        if (w_emit) begin
            if (r_neg_pend) begin
                r_char     <= sida_pkg::CharMinus;
                r_last     <= 1'b0;
                r_neg_pend <= 1'b0;
            end else begin
                r_char <= sida_pkg::CharZero + sida_pkg::CharWidth'(w_digit[r_idx]);
                r_last <= (r_idx == '0);
                r_idx  <= r_idx - sida_pkg::DigitIdxWidth'(1);
            end
        end
    end

    assign i_in.ready      = w_in_ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.char_code = r_char;
    assign o_out.is_last   = r_last;

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.char_code == sida_pkg::CharMinus) |-> !o_out.is_last)
        else $error("minus sign flagged as last character");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.char_code == sida_pkg::CharMinus ||
                         (o_out.char_code >= sida_pkg::CharZero &&
                          o_out.char_code <= sida_pkg::CharZero + sida_pkg::CharWidth'(9))))
        else $error("character code out of range");

    a_accept_starts_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == sida_pkg::ST_CONV && r_step == '0))
        else $error("accepted item did not start conversion");

    a_top_digit_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sida_pkg::ST_COUNT) |-> (w_digit[sida_pkg::NumDigits-1] <= 4'd4))
        else $error("top decimal digit overflow");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sida_pkg::ST_EMIT) |->
            (r_idx <= sida_pkg::DigitIdxWidth'(sida_pkg::NumDigits - 1)))
        else $error("digit index out of range");

endmodule
`default_nettype wire
